@@ hdl/assert_macros.svh @@
// Assertion macros for the RTL files; the parser top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ITP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ITP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/itp_pkg.sv @@
// Types, codes and lookup functions of the timestamp parser.
package itp_pkg;

    localparam int MAC_A_W = 25;
    localparam int MAC_B_W = 19;
    localparam int ACC_W   = 40;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_SHAPE      = 3'd2;
    localparam logic [2:0] ST_RANGE      = 3'd3;
    localparam logic [2:0] ST_ZONE_FMT   = 3'd4;
    localparam logic [2:0] ST_ZONE_RANGE = 3'd5;
    localparam logic [2:0] ST_ZONE_BAD   = 3'd6;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [4:0] FIXED_LEN = 5'd19;
    localparam logic [4:0] POS_SAT   = 5'd20;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic signed [38:0] utc_seconds;
        logic [2:0]         status;
    } out_word_t;

    typedef enum logic [5:0] {
        PH_FIXED   = 6'b000001,
        PH_AFTER   = 6'b000010,
        PH_FRAC    = 6'b000100,
        PH_ZONE    = 6'b001000,
        PH_IGNORE  = 6'b010000,
        PH_BADZONE = 6'b100000
    } phase_t;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_ERA  = 14'b00000000000010,
        S_YOE  = 14'b00000000000100,
        S_Q100 = 14'b00000000001000,
        S_DOE  = 14'b00000000010000,
        S_DAYS = 14'b00000000100000,
        S_SECH = 14'b00000001000000,
        S_SECM = 14'b00000010000000,
        S_SECD = 14'b00000100000000,
        S_ZQ   = 14'b00001000000000,
        S_ZR   = 14'b00010000000000,
        S_ZH   = 14'b00100000000000,
        S_ZM   = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } seq_t;

    // Days before the first of the month, in a year that starts in March.
    function automatic logic [8:0] march_days(input logic [6:0] m);
        logic [8:0] r;
        unique case (m)
            7'd3:    r = 9'd0;
            7'd4:    r = 9'd31;
            7'd5:    r = 9'd61;
            7'd6:    r = 9'd92;
            7'd7:    r = 9'd122;
            7'd8:    r = 9'd153;
            7'd9:    r = 9'd184;
            7'd10:   r = 9'd214;
            7'd11:   r = 9'd245;
            7'd12:   r = 9'd275;
            7'd1:    r = 9'd306;
            7'd2:    r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Length of a month; zero for a month number that means nothing.
    function automatic logic [4:0] month_limit(input logic [6:0] m, input logic leap);
        logic [4:0] r;
        unique case (m)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                    r = 5'd30;
            7'd2:                                        r = leap ? 5'd29 : 5'd28;
            default:                                     r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [13:0] dec14(input logic [13:0] acc, input logic [3:0] v);
        return {acc[10:0], 3'b000} + {acc[12:0], 1'b0} + {10'd0, v};
    endfunction

    function automatic logic [6:0] dec7(input logic [6:0] acc, input logic [3:0] v);
        return {acc[3:0], 3'b000} + {acc[5:0], 1'b0} + {3'd0, v};
    endfunction

endpackage

@@ hdl/iso8601_timestamp_parser.sv @@
// Top level of the ISO-8601 timestamp to epoch seconds parser.
//
// Input channel src_valid/src_stall/src_data carries one character a word,
// with a last flag on the final character of each string. Output channel
// res_valid/res_stall/res_data carries one word a string: epoch seconds and
// a status, given once the last character has been taken.
// Characters are taken one per cycle while src_stall is low. After the last
// character a sequencer drives one shared multiply-add unit through twelve
// steps (day count, time of day, zone offset), then waits in a final state
// until the output register can take the result word. src_stall is high
// throughout that time, from the last character until the result is loaded.
// The result waits in an output register while res_stall is high; a new
// string may stream in meanwhile, but its result waits for that register
// to empty. Reset clears the parser, the sequencer and the output valid.
`include "assert_macros.svh"

module iso8601_timestamp_parser
    import itp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  in_word_t  src_data,
    output logic      res_valid,
    input  logic      res_stall,
    output out_word_t res_data
);

    // Parser state
    logic [4:0]  pos_reg, pos_next;
    phase_t      phase_reg, phase_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  mon_reg, mon_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hr_reg, hr_next;
    logic [6:0]  min_reg, min_next;
    logic [6:0]  sec_reg, sec_next;
    logic        shape_reg, shape_next;
    logic        zneg_reg, zneg_next;
    logic [13:0] zdig_reg, zdig_next;
    logic [2:0]  zcnt_reg, zcnt_next;
    logic [6:0]  zmin_reg, zmin_next;
    logic [4:0]  znd_reg, znd_next;
    logic        zcolon_reg, zcolon_next;

    // Sequencer and arithmetic state
    seq_t               state_reg, state_next;
    logic [4:0]         era_reg, era_next;
    logic [8:0]         yoe_reg, yoe_next;
    logic [1:0]         q100_reg, q100_next;
    logic signed [20:0] doe_reg, doe_next;
    logic signed [22:0] days_reg, days_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [6:0]         oh_reg, oh_next;
    logic [6:0]         om_reg, om_next;

    logic      res_valid_reg, res_valid_next;
    out_word_t res_data_reg, res_data_next;

    logic signed [MAC_A_W-1:0] mac_a;
    logic signed [MAC_B_W-1:0] mac_b;
    logic signed [ACC_W-1:0]   mac_c;
    logic signed [ACC_W-1:0]   mac_r;

    logic        src_acc;
    logic        done_load;
    logic [7:0]  c;
    logic        is_dig;
    logic [3:0]  v;
    logic        marker;
    logic        mon_le2;
    logic [13:0] yy;
    logic [8:0]  doy;
    logic        colon_form;
    logic        leap;
    logic [2:0]  status;

    itp_mac u_mac (
        .op_a   (mac_a),
        .op_b   (mac_b),
        .addend (mac_c),
        .sum    (mac_r)
    );

    assign src_stall = (state_reg != S_IDLE);
    assign src_acc   = src_valid && !src_stall;
    assign done_load = (state_reg == S_DONE) && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    assign c      = src_data.char_code;
    assign is_dig = (c >= 8'h30) && (c <= 8'h39);
    assign v      = is_dig ? c[3:0] : 4'd0;

    // Parse one character into the field accumulators.
    always_comb
    begin
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        year_next   = year_reg;
        mon_next    = mon_reg;
        day_next    = day_reg;
        hr_next     = hr_reg;
        min_next    = min_reg;
        sec_next    = sec_reg;
        shape_next  = shape_reg;
        zneg_next   = zneg_reg;
        zdig_next   = zdig_reg;
        zcnt_next   = zcnt_reg;
        zmin_next   = zmin_reg;
        znd_next    = znd_reg;
        zcolon_next = zcolon_reg;
        marker      = 1'b0;
        if (src_acc)
        begin
            if (pos_reg < POS_SAT)
            begin
                pos_next = pos_reg + 5'd1;
            end
            unique case (phase_reg)
                PH_FIXED:
                begin
                    priority if (pos_reg == 5'd4 || pos_reg == 5'd7)
                    begin
                        if (c != CH_DASH) shape_next = 1'b1;
                    end
                    else if (pos_reg == 5'd10)
                    begin
                        if (c != CH_T) shape_next = 1'b1;
                    end
                    else if (pos_reg == 5'd13 || pos_reg == 5'd16)
                    begin
                        if (c != CH_COLON) shape_next = 1'b1;
                    end
                    else
                    begin
                        if (!is_dig) shape_next = 1'b1;
                        priority if (pos_reg < 5'd4)  year_next = dec14(year_reg, v);
                        else if (pos_reg < 5'd7)      mon_next  = dec7(mon_reg, v);
                        else if (pos_reg < 5'd10)     day_next  = dec7(day_reg, v);
                        else if (pos_reg < 5'd13)     hr_next   = dec7(hr_reg, v);
                        else if (pos_reg < 5'd16)     min_next  = dec7(min_reg, v);
                        else                          sec_next  = dec7(sec_reg, v);
                    end
                    if (pos_reg >= FIXED_LEN - 5'd1)
                    begin
                        phase_next = PH_AFTER;
                    end
                end
                PH_AFTER:
                begin
                    if (c == CH_DOT) phase_next = PH_FRAC;
                    else             marker = 1'b1;
                end
                PH_FRAC:
                begin
                    if (!is_dig) marker = 1'b1;
                end
                PH_ZONE:
                begin
                    if (zcnt_reg < 3'd5)
                    begin
                        if (!is_dig) znd_next[zcnt_reg] = 1'b1;
                        if (zcnt_reg < 3'd4) zdig_next = dec14(zdig_reg, v);
                        if (zcnt_reg == 3'd2 && c == CH_COLON) zcolon_next = 1'b1;
                        if (zcnt_reg >= 3'd3) zmin_next = dec7(zmin_reg, v);
                    end
                    if (zcnt_reg < 3'd7) zcnt_next = zcnt_reg + 3'd1;
                end
                PH_IGNORE, PH_BADZONE:
                begin
                end
                default:
                begin
                end
            endcase
            // Decode the zone marker.
            if (marker)
            begin
                priority if (c == CH_Z)
                begin
                    phase_next = PH_IGNORE;
                end
                else if (c == CH_PLUS || c == CH_DASH)
                begin
                    phase_next = PH_ZONE;
                    zneg_next  = (c == CH_DASH);
                end
                else
                begin
                    phase_next = PH_BADZONE;
                end
            end
        end
        // Drop the string once its result is loaded.
        if (done_load)
        begin
            pos_next    = '0;
            phase_next  = PH_FIXED;
            year_next   = '0;
            mon_next    = '0;
            day_next    = '0;
            hr_next     = '0;
            min_next    = '0;
            sec_next    = '0;
            shape_next  = 1'b0;
            zneg_next   = 1'b0;
            zdig_next   = '0;
            zcnt_next   = '0;
            zmin_next   = '0;
            znd_next    = '0;
            zcolon_next = 1'b0;
        end
    end

    assign mon_le2    = (mon_reg <= 7'd2);
    assign yy         = year_reg + 14'd400 - {13'd0, mon_le2};
    assign doy        = march_days(mon_reg) + {2'd0, day_reg} - 9'd1;
    assign colon_form = (zcnt_reg == 3'd5) && zcolon_reg;
    // Valid for February only, where yoe is the year minus one, modulo 400.
    assign leap = ((year_reg[1:0] == 2'b00) &&
                   !(yoe_reg == 9'd399 || yoe_reg == 9'd99 ||
                     yoe_reg == 9'd199 || yoe_reg == 9'd299)) ||
                  (yoe_reg == 9'd399);

    // Order the status checks.
    always_comb
    begin
        priority if (pos_reg < FIXED_LEN)
            status = ST_SHORT;
        else if (shape_reg)
            status = ST_SHAPE;
        else if (mon_reg < 7'd1 || mon_reg > 7'd12 || day_reg < 7'd1 ||
                 day_reg > {2'd0, month_limit(mon_reg, leap)} ||
                 hr_reg > 7'd23 || min_reg > 7'd59 || sec_reg > 7'd59)
            status = ST_RANGE;
        else if (phase_reg == PH_BADZONE)
            status = ST_ZONE_BAD;
        else if (phase_reg == PH_ZONE && colon_form && (znd_reg & 5'h1B) != 5'h00)
            status = ST_ZONE_FMT;
        else if (phase_reg == PH_ZONE && !colon_form &&
                 (zcnt_reg < 3'd4 || (znd_reg & 5'h0F) != 5'h00))
            status = ST_ZONE_FMT;
        else if (phase_reg == PH_ZONE && (oh_reg > 7'd23 || om_reg > 7'd59))
            status = ST_ZONE_RANGE;
        else
            status = ST_OK;
    end

    // Step the sequencer through the shared multiply-add unit.
    always_comb
    begin
        state_next     = state_reg;
        era_next       = era_reg;
        yoe_next       = yoe_reg;
        q100_next      = q100_reg;
        doe_next       = doe_reg;
        days_next      = days_reg;
        acc_next       = acc_reg;
        oh_next        = oh_reg;
        om_next        = om_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        mac_a          = '0;
        mac_b          = '0;
        mac_c          = '0;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (src_acc && src_data.last) state_next = S_ERA;
            end
            S_ERA:
            begin
                mac_a      = $signed({11'd0, yy});
                mac_b      = 19'sd5243;
                era_next   = mac_r[25:21];
                state_next = S_YOE;
            end
            S_YOE:
            begin
                mac_c      = $signed({26'd0, yy});
                mac_a      = $signed({20'd0, era_reg});
                mac_b      = -19'sd400;
                yoe_next   = mac_r[8:0];
                state_next = S_Q100;
            end
            S_Q100:
            begin
                mac_a      = $signed({16'd0, yoe_reg});
                mac_b      = 19'sd41;
                q100_next  = mac_r[13:12];
                state_next = S_DOE;
            end
            S_DOE:
            begin
                mac_c = $signed({33'd0, yoe_reg[8:2]}) - $signed({38'd0, q100_reg})
                      + $signed({31'd0, doy}) - 40'sd865565;
                mac_a      = $signed({16'd0, yoe_reg});
                mac_b      = 19'sd365;
                doe_next   = mac_r[20:0];
                state_next = S_DAYS;
            end
            S_DAYS:
            begin
                mac_c      = ACC_W'(doe_reg);
                mac_a      = $signed({20'd0, era_reg});
                mac_b      = 19'sd146097;
                days_next  = mac_r[22:0];
                state_next = S_SECH;
            end
            S_SECH:
            begin
                mac_c      = $signed({33'd0, sec_reg});
                mac_a      = $signed({18'd0, hr_reg});
                mac_b      = 19'sd3600;
                acc_next   = mac_r;
                state_next = S_SECM;
            end
            S_SECM:
            begin
                mac_c      = acc_reg;
                mac_a      = $signed({18'd0, min_reg});
                mac_b      = 19'sd60;
                acc_next   = mac_r;
                state_next = S_SECD;
            end
            S_SECD:
            begin
                mac_c      = acc_reg;
                mac_a      = MAC_A_W'(days_reg);
                mac_b      = 19'sd86400;
                acc_next   = mac_r;
                state_next = S_ZQ;
            end
            S_ZQ:
            begin
                mac_a      = $signed({11'd0, zdig_reg});
                mac_b      = 19'sd5243;
                oh_next    = mac_r[25:19];
                state_next = S_ZR;
            end
            S_ZR:
            begin
                mac_c      = $signed({26'd0, zdig_reg});
                mac_a      = $signed({18'd0, oh_reg});
                mac_b      = -19'sd100;
                om_next    = colon_form ? zmin_reg : mac_r[6:0];
                state_next = S_ZH;
            end
            S_ZH:
            begin
                mac_c      = acc_reg;
                mac_a      = $signed({18'd0, oh_reg});
                mac_b      = zneg_reg ? 19'sd3600 : -19'sd3600;
                acc_next   = mac_r;
                state_next = S_ZM;
            end
            S_ZM:
            begin
                mac_c      = acc_reg;
                mac_a      = $signed({18'd0, om_reg});
                mac_b      = zneg_reg ? 19'sd60 : -19'sd60;
                acc_next   = mac_r;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // Hold until the output register is free.
                if (done_load)
                begin
                    res_valid_next             = 1'b1;
                    res_data_next.status       = status;
                    res_data_next.utc_seconds  = (status == ST_OK) ? acc_reg[38:0] : '0;
                    state_next                 = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FIXED;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
            shape_reg     <= 1'b0;
            zcnt_reg      <= '0;
            zcolon_reg    <= 1'b0;
            znd_reg       <= '0;
            zneg_reg      <= 1'b0;
            year_reg      <= '0;
            mon_reg       <= '0;
            day_reg       <= '0;
            hr_reg        <= '0;
            min_reg       <= '0;
            sec_reg       <= '0;
            zdig_reg      <= '0;
            zmin_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
            shape_reg     <= shape_next;
            zcnt_reg      <= zcnt_next;
            zcolon_reg    <= zcolon_next;
            znd_reg       <= znd_next;
            zneg_reg      <= zneg_next;
            year_reg      <= year_next;
            mon_reg       <= mon_next;
            day_reg       <= day_next;
            hr_reg        <= hr_next;
            min_reg       <= min_next;
            sec_reg       <= sec_next;
            zdig_reg      <= zdig_next;
            zmin_reg      <= zmin_next;
        end
    end

    // Arithmetic and output payload registers
    always_ff @(posedge clk)
    begin
        era_reg      <= era_next;
        yoe_reg      <= yoe_next;
        q100_reg     <= q100_next;
        doe_reg      <= doe_next;
        days_reg     <= days_next;
        acc_reg      <= acc_next;
        oh_reg       <= oh_next;
        om_reg       <= om_next;
        res_data_reg <= res_data_next;
    end

    `ITP_ASSERT(a_last_starts_seq, clk, rst_n, src_valid && !src_stall && src_data.last |=> state_reg == S_ERA, "last word did not start the sequencer")
    `ITP_ASSERT(a_result_from_done, clk, rst_n, $rose(res_valid) |-> $past(state_reg == S_DONE), "result appeared outside the final step")
    `ITP_ASSERT(a_error_zero_epoch, clk, rst_n, res_valid && res_data.status != ST_OK |-> res_data.utc_seconds == '0, "failed string carries nonzero seconds")
    `ITP_ASSERT_ALWAYS(a_seq_onehot, clk, $onehot(state_reg) || !rst_n, "sequencer state lost its one-hot code")

endmodule

@@ hdl/itp_mac.sv @@
// Shared multiply-add unit of the date and time arithmetic.
module itp_mac
    import itp_pkg::*;
(
    input  logic signed [MAC_A_W-1:0] op_a,
    input  logic signed [MAC_B_W-1:0] op_b,
    input  logic signed [ACC_W-1:0]   addend,
    output logic signed [ACC_W-1:0]   sum
);

    logic signed [MAC_A_W+MAC_B_W-1:0] prod;

    // Multiply, then add the running term.
    assign prod = op_a * op_b;
    assign sum  = addend + $signed(prod[ACC_W-1:0]);

endmodule
